// ----- rtl/cls_pkg.sv -----
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and fixed field widths for the compacting list store.
// ----------------------------------------------------------------------------
package cls_pkg;

   localparam int OP_W        = 3;
   localparam int INDEX_W     = 6;
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND  = 3'd0,
      OP_SET     = 3'd1,
      OP_READ    = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_REVERSE = 3'd4,
      OP_REMOVE  = 3'd5,
      OP_FIND    = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_WAIT,
      S_REV_SWAP,
      S_REV_WRITE,
      S_RM_SCAN,
      S_FD_SCAN
   } state_type;

endpackage

// ----- rtl/compacting_list_store.sv -----
// ----------------------------------------------------------------------------
// compacting_list_store
// Bounded ordered list of words with append, set, read, clear, reverse,
// remove-all-equal with compaction and find-first, driven by one sequencer
// around a single-port-pair entry store and one shared equality compare.
//
//   channel   handshake                 word
//   request   start / busy              req_op, req_entry_index, req_entry_value
//   response  rsp_strobe (one cycle)    rsp_read_value, rsp_found,
//                                       rsp_found_index, rsp_entry_count, rsp_status
//
// append, set, clear and rejected requests: response in the cycle after start.
// read: word taken in S_RD_WAIT. reverse: S_REV_SWAP then S_REV_WRITE a pair.
// remove and find: one entry compared per cycle.
// reset clears the count and the sequencer; stored words keep no reset value.
// busy is high from the cycle after start until the response when S_IDLE is
// left. a new start is taken in the cycle the response shows; no hold-off.
// ----------------------------------------------------------------------------
module compacting_list_store #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [cls_pkg::OP_W-1:0]               req_op,
   input  logic [cls_pkg::INDEX_W-1:0]            req_entry_index,
   input  logic [cls_pkg::VALUE_W-1:0]            req_entry_value,
   output logic                                   rsp_strobe,
   output logic [cls_pkg::VALUE_W-1:0]            rsp_read_value,
   output logic                                   rsp_found,
   output logic [cls_pkg::INDEX_W-1:0]            rsp_found_index,
   output logic [cls_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   output cls_pkg::status_type                    rsp_status
);

   import cls_pkg::*;

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int IXW = (CW > INDEX_W) ? CW : INDEX_W;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic [CW-1:0]           hi_ff, hi_in;
   logic [CW-1:0]           dst_ff, dst_in;
   logic [DATA_WIDTH-1:0]   value_ff, value_in;
   logic                    strobe_ff, strobe_in;
   logic [VALUE_W-1:0]      rvalue_ff, rvalue_in;
   logic                    found_ff, found_in;
   logic [INDEX_W-1:0]      findex_ff, findex_in;
   status_type              status_ff, status_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [DATA_WIDTH-1:0]   ram_wdata;
   logic [AW-1:0]           ram_raddr;
   logic [DATA_WIDTH-1:0]   ram_rdata;

   logic [DATA_WIDTH-1:0]   req_value;
   logic [IXW-1:0]          idx_w;
   logic [IXW-1:0]          cnt_w;
   logic                    idx_bad;
   logic                    match;
   logic                    last;
   logic [CW-1:0]           ptr_next;
   logic [CW:0]             ptr_plus2;

   cls_ram #(
      .DEPTH  (CAPACITY),
      .DATA_W (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_value = DATA_WIDTH'(req_entry_value);
   assign idx_w     = IXW'(req_entry_index);
   assign cnt_w     = IXW'(count_ff);
   assign idx_bad   = (idx_w >= cnt_w);
   // shared compare for remove and find
   assign match     = (ram_rdata == value_ff);
   assign last      = (ptr_ff == (count_ff - CW'(1)));
   assign ptr_next  = ptr_ff + CW'(1);
   assign ptr_plus2 = {1'b0, ptr_ff} + (CW + 1)'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      hi_ff     <= hi_in;
      dst_ff    <= dst_in;
      value_ff  <= value_in;
      rvalue_ff <= rvalue_in;
      found_ff  <= found_in;
      findex_ff <= findex_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      hi_in     = hi_ff;
      dst_in    = dst_ff;
      value_in  = value_ff;
      strobe_in = 1'b0;
      rvalue_in = rvalue_ff;
      found_in  = found_ff;
      findex_in = findex_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in  = req_value;
               rvalue_in = '0;
               found_in  = 1'b0;
               findex_in = '0;
               status_in = ST_OK;
               case (op_type'(req_op))
                  OP_APPEND: begin
                     strobe_in = 1'b1;
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[AW-1:0];
                        ram_wdata = req_value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_SET: begin
                     strobe_in = 1'b1;
                     if (idx_bad) begin
                        status_in = ST_RANGE;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_w[AW-1:0];
                        ram_wdata = req_value;
                     end
                  end
                  OP_READ: begin
                     if (idx_bad) begin
                        status_in = ST_RANGE;
                        strobe_in = 1'b1;
                     end else begin
                        ram_raddr = idx_w[AW-1:0];
                        state_in  = S_RD_WAIT;
                     end
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     strobe_in = 1'b1;
                  end
                  OP_REVERSE: begin
                     if (count_ff < CW'(2)) begin
                        strobe_in = 1'b1;
                     end else begin
                        ram_raddr = '0;
                        ptr_in    = '0;
                        hi_in     = count_ff - CW'(1);
                        state_in  = S_REV_SWAP;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                     end else begin
                        ram_raddr = '0;
                        ptr_in    = '0;
                        dst_in    = '0;
                        state_in  = S_RM_SCAN;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                     end else begin
                        ram_raddr = '0;
                        ptr_in    = '0;
                        state_in  = S_FD_SCAN;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            rvalue_in = VALUE_W'(ram_rdata);
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_REV_SWAP: begin
            // low word arrives; fetch the high word and overwrite it
            ram_raddr = hi_ff[AW-1:0];
            ram_we    = 1'b1;
            ram_waddr = hi_ff[AW-1:0];
            ram_wdata = ram_rdata;
            state_in  = S_REV_WRITE;
         end
         S_REV_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[AW-1:0];
            ram_wdata = ram_rdata;
            ptr_in    = ptr_next;
            hi_in     = hi_ff - CW'(1);
            if (ptr_plus2 < {1'b0, hi_ff}) begin
               ram_raddr = ptr_next[AW-1:0];
               state_in  = S_REV_SWAP;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_RM_SCAN: begin
            if (!match) begin
               ram_we    = 1'b1;
               ram_waddr = dst_ff[AW-1:0];
               ram_wdata = ram_rdata;
               dst_in    = dst_ff + CW'(1);
            end
            if (last) begin
               count_in  = match ? dst_ff : (dst_ff + CW'(1));
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               ram_raddr = ptr_next[AW-1:0];
               ptr_in    = ptr_next;
            end
         end
         S_FD_SCAN: begin
            if (match) begin
               found_in  = 1'b1;
               findex_in = INDEX_W'(ptr_ff);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else if (last) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               ram_raddr = ptr_next[AW-1:0];
               ptr_in    = ptr_next;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_read_value  = rvalue_ff;
   assign rsp_found       = found_ff;
   assign rsp_found_index = findex_ff;
   assign rsp_entry_count = COUNT_OUT_W'(count_ff);
   assign rsp_status      = status_ff;

`ifndef SYNTHESIS
   a_strobe_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start || busy))
      else $error("response word without a request");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL)) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status with room left");

   a_reverse_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REV_WRITE) |-> (ptr_ff < hi_ff))
      else $error("reverse pointers crossed");
`endif

endmodule

// ----- rtl/cls_ram.sv -----
// ----------------------------------------------------------------------------
// cls_ram
// Entry store: one write port, one read port with registered read data.
// A read and a write of the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module cls_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
